[src/bsp_pkg.sv]
// Shared types and constants for the bit stream packer.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package bsp_pkg;

   localparam int STORE_WORDS_DEFAULT = 1024;

   localparam int DATA_W     = 64;
   localparam int COUNT_W    = 7;
   localparam int OFFSET_W   = 16;
   localparam int POS_W      = 17;
   localparam int SHIFT_W    = 6;
   localparam int WORD_IDX_W = POS_W - SHIFT_W;
   localparam int CSR_W      = 11;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(1024);
   localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_READ   = 1'b1
   } bsp_op_type;

   typedef struct packed {
      bsp_op_type          op;
      logic [DATA_W-1:0]   data_bits;
      logic [COUNT_W-1:0]  append_len;
      logic [OFFSET_W-1:0] bit_offset;
   } bsp_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_bits;
      logic               ok;
      logic [COUNT_W-1:0] bits_taken;
      logic [POS_W-1:0]   position;
   } bsp_rsp_type;

   typedef struct packed {
      bsp_op_type           op;
      logic                 ok;
      logic                 hi_use;
      logic [WORD_IDX_W-1:0] lo_idx;
      logic [SHIFT_W-1:0]   shift;
      logic [DATA_W-1:0]    bits;
      logic [COUNT_W-1:0]   taken;
      logic [POS_W-1:0]     position;
   } bsp_stage_type;

endpackage
`default_nettype wire

[src/bsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsp_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output      logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[src/bsp_issue.sv]
// Request stage: register, word limit, write position, bank read addresses.
// Depends on bsp_pkg.
`default_nettype none
module bsp_issue #(
   parameter int STORE_WORDS = bsp_pkg::STORE_WORDS_DEFAULT,
   parameter int BANK_AW     = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire bsp_pkg::bsp_req_type          req_item,
   input  wire logic                          csr_we,
   input  wire logic [bsp_pkg::CSR_W-1:0]     csr_wdata,
   output      logic [BANK_AW-1:0]            rd_addr_even,
   output      logic [BANK_AW-1:0]            rd_addr_odd,
   output      logic                          s1_valid,
   output      bsp_pkg::bsp_stage_type        s1_stage
);

   localparam int IW = bsp_pkg::WORD_IDX_W;
   localparam int SW = bsp_pkg::SHIFT_W;
   localparam int PW = bsp_pkg::POS_W;
   localparam int CW = bsp_pkg::COUNT_W;
   localparam int DW = bsp_pkg::DATA_W;

   logic [bsp_pkg::CSR_W-1:0] csr_ff;
   logic [PW-1:0]             pos_ff;
   logic [PW-1:0]             pos_in;
   logic                      s1_valid_ff;
   bsp_pkg::bsp_stage_type    s1_stage_ff;
   bsp_pkg::bsp_stage_type    s1_stage_in;

   logic [bsp_pkg::CSR_W-1:0] limit;
   logic                      accept;
   logic                      is_read;
   logic [IW-1:0]             word_idx;
   logic [IW:0]               next_idx;
   logic [SW-1:0]             shift;
   logic                      in_range;
   logic                      hi_use;
   logic [CW-1:0]             count;
   logic [DW-1:0]             sel;
   logic [PW:0]               pos_sum;
   logic [PW-1:0]             pos_sat;

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign is_read = (req_item.op == bsp_pkg::OP_READ);

   assign limit = (32'(csr_ff) > STORE_WORDS) ? bsp_pkg::CSR_W'(STORE_WORDS) : csr_ff;

   assign word_idx = is_read ? IW'(req_item.bit_offset[bsp_pkg::OFFSET_W-1:SW])
                             : pos_ff[PW-1:SW];
   assign shift    = is_read ? req_item.bit_offset[SW-1:0] : pos_ff[SW-1:0];
   assign next_idx = {1'b0, word_idx} + (IW+1)'(1);
   assign in_range = (word_idx < limit);
   assign hi_use   = (shift != '0) && (next_idx < {1'b0, limit});

   assign count   = (req_item.append_len > CW'(DW)) ? CW'(DW) : req_item.append_len;
   assign sel     = req_item.data_bits & ~({DW{1'b1}} << count);
   assign pos_sum = {1'b0, pos_ff} + (PW+1)'(count);
   assign pos_sat = pos_sum[PW] ? bsp_pkg::POS_MAX : pos_sum[PW-1:0];
   assign pos_in  = (accept && !is_read && in_range) ? pos_sat : pos_ff;

   always_comb begin
      s1_stage_in          = s1_stage_ff;
      s1_stage_in.op       = req_item.op;
      s1_stage_in.ok       = in_range;
      s1_stage_in.hi_use   = hi_use;
      s1_stage_in.lo_idx   = word_idx;
      s1_stage_in.shift    = shift;
      s1_stage_in.bits     = sel;
      s1_stage_in.taken    = (!is_read && in_range) ? count : '0;
      s1_stage_in.position = pos_in;
   end

   assign rd_addr_even = BANK_AW'(next_idx >> 1);
   assign rd_addr_odd  = BANK_AW'(word_idx >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff      <= bsp_pkg::CSR_RESET;
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         pos_ff      <= pos_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stage_ff <= s1_stage_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_stage = s1_stage_ff;

endmodule
`default_nettype wire

[src/bsp_merge.sv]
// Merge stage: bypass, fill count, shift and merge, bank writes, response register.
// Depends on bsp_pkg.
`default_nettype none
module bsp_merge #(
   parameter int STORE_WORDS = bsp_pkg::STORE_WORDS_DEFAULT,
   parameter int BANK_AW     = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          s1_valid,
   input  wire bsp_pkg::bsp_stage_type        s1_stage,
   input  wire logic [bsp_pkg::DATA_W-1:0]    even_rdata,
   input  wire logic [bsp_pkg::DATA_W-1:0]    odd_rdata,
   output      logic                          even_we,
   output      logic [BANK_AW-1:0]            even_waddr,
   output      logic [bsp_pkg::DATA_W-1:0]    even_wdata,
   output      logic                          odd_we,
   output      logic [BANK_AW-1:0]            odd_waddr,
   output      logic [bsp_pkg::DATA_W-1:0]    odd_wdata,
   output      logic                          rsp_strobe,
   output      bsp_pkg::bsp_rsp_type          rsp_item
);

   localparam int CNT_W = $clog2(STORE_WORDS + 1);
   localparam int IW    = bsp_pkg::WORD_IDX_W;
   localparam int DW    = bsp_pkg::DATA_W;
   localparam int SW    = bsp_pkg::SHIFT_W;

   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic               even_fwd_vld_ff;
   logic [BANK_AW-1:0] even_fwd_addr_ff;
   logic [DW-1:0]      even_fwd_data_ff;
   logic               odd_fwd_vld_ff;
   logic [BANK_AW-1:0] odd_fwd_addr_ff;
   logic [DW-1:0]      odd_fwd_data_ff;
   logic               rsp_strobe_ff;
   bsp_pkg::bsp_rsp_type rsp_item_ff;
   bsp_pkg::bsp_rsp_type rsp_item_in;

   logic               lo_odd;
   logic [IW:0]        next_idx;
   logic [BANK_AW-1:0] even_addr;
   logic [BANK_AW-1:0] odd_addr;
   logic [DW-1:0]      even_q;
   logic [DW-1:0]      odd_q;
   logic [DW-1:0]      lo_raw;
   logic [DW-1:0]      hi_raw;
   logic               lo_known;
   logic               hi_known;
   logic [DW-1:0]      lo_word;
   logic [DW-1:0]      hi_word;
   logic [SW-1:0]      rev_shift;
   logic [DW-1:0]      read_val;
   logic [DW-1:0]      lo_new;
   logic [DW-1:0]      hi_new;
   logic               is_write;
   logic               lo_we;
   logic               hi_we;
   logic [CNT_W-1:0]   fill_cand;

   assign lo_odd    = s1_stage.lo_idx[0];
   assign next_idx  = {1'b0, s1_stage.lo_idx} + (IW+1)'(1);
   assign even_addr = BANK_AW'(next_idx >> 1);
   assign odd_addr  = BANK_AW'(s1_stage.lo_idx >> 1);

   assign even_q = (even_fwd_vld_ff && (even_fwd_addr_ff == even_addr)) ? even_fwd_data_ff
                                                                        : even_rdata;
   assign odd_q  = (odd_fwd_vld_ff && (odd_fwd_addr_ff == odd_addr)) ? odd_fwd_data_ff
                                                                    : odd_rdata;
   assign lo_raw = lo_odd ? odd_q : even_q;
   assign hi_raw = lo_odd ? even_q : odd_q;

   assign lo_known = (32'(s1_stage.lo_idx) < 32'(fill_ff));
   assign hi_known = (32'(next_idx) < 32'(fill_ff));
   assign lo_word  = lo_known ? lo_raw : '0;
   assign hi_word  = (s1_stage.hi_use && hi_known) ? hi_raw : '0;

   assign rev_shift = SW'(DW - 1) - s1_stage.shift;
   assign read_val  = (lo_word >> s1_stage.shift) | ((hi_word << 1) << rev_shift);
   assign lo_new    = lo_word | (s1_stage.bits << s1_stage.shift);
   assign hi_new    = hi_word | ((s1_stage.bits >> 1) >> rev_shift);

   assign is_write = s1_valid && (s1_stage.op == bsp_pkg::OP_APPEND) && s1_stage.ok;
   assign lo_we    = is_write;
   assign hi_we    = is_write && s1_stage.hi_use;

   assign even_we    = lo_odd ? hi_we : lo_we;
   assign even_waddr = even_addr;
   assign even_wdata = lo_odd ? hi_new : lo_new;
   assign odd_we     = lo_odd ? lo_we : hi_we;
   assign odd_waddr  = odd_addr;
   assign odd_wdata  = lo_odd ? lo_new : hi_new;

   assign fill_cand = CNT_W'(next_idx) + CNT_W'(hi_we);
   assign fill_in   = (lo_we && (fill_cand > fill_ff)) ? fill_cand : fill_ff;

   always_comb begin
      rsp_item_in            = rsp_item_ff;
      rsp_item_in.read_bits  = ((s1_stage.op == bsp_pkg::OP_READ) && s1_stage.ok) ? read_val
                                                                                 : '0;
      rsp_item_in.ok         = s1_stage.ok;
      rsp_item_in.bits_taken = s1_stage.taken;
      rsp_item_in.position   = s1_stage.position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         even_fwd_vld_ff <= 1'b0;
         odd_fwd_vld_ff  <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         fill_ff         <= fill_in;
         even_fwd_vld_ff <= even_we;
         odd_fwd_vld_ff  <= odd_we;
         rsp_strobe_ff   <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      even_fwd_addr_ff <= even_addr;
      even_fwd_data_ff <= even_wdata;
      odd_fwd_addr_ff  <= odd_addr;
      odd_fwd_data_ff  <= odd_wdata;
      if (s1_valid) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef ASSERT_OFF
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      s1_valid |=> rsp_strobe_ff)
      else $error("response strobe missing after merge stage");

   a_span_write: assert property (@(posedge clock) disable iff (reset)
      (even_we && odd_we) |-> (s1_stage.hi_use && (s1_stage.shift != '0)))
      else $error("both banks written without a spanning write");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fill_ff >= $past(fill_ff)))
      else $error("fill count went down");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= STORE_WORDS)
      else $error("fill count beyond store");

   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_item_ff.ok) |->
         ((rsp_item_ff.read_bits == '0) && (rsp_item_ff.bits_taken == '0)))
      else $error("failed request returned data or took bits");
`endif

endmodule
`default_nettype wire

[src/bit_stream_packer_core.sv]
// Top level of the bit stream packer: request stage, two word banks, merge stage.
// Depends on bsp_pkg, bsp_ram, bsp_issue and bsp_merge.
`default_nettype none
// One request is taken in every clock cycle (busy stays low) and its response
// is strobed on rsp_strobe for one cycle, after the s1_valid and rsp_strobe
// registers; the response cannot be held off, so take it when it appears. The
// store is split into an even-word bank and an odd-word bank, each a RAM with
// a registered read, so the two adjacent words a request touches are read in
// the cycle it is taken and rewritten by an append in the next; a one-entry
// bypass per bank covers back-to-back requests. The store comes out of reset
// logically zero at once: a fill count marks the words written so far, and no
// clearing pass runs. Write csr_wdata only while no request is in flight.
module bit_stream_packer_core #(
   parameter int STORE_WORDS = bsp_pkg::STORE_WORDS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire bsp_pkg::bsp_req_type      req_item,
   output      logic                      rsp_strobe,
   output      bsp_pkg::bsp_rsp_type      rsp_item,
   input  wire logic                      csr_we,
   input  wire logic [bsp_pkg::CSR_W-1:0] csr_wdata
);

   localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [BANK_AW-1:0]          rd_addr_even;
   logic [BANK_AW-1:0]          rd_addr_odd;
   logic                        s1_valid;
   bsp_pkg::bsp_stage_type      s1_stage;
   logic [bsp_pkg::DATA_W-1:0]  even_rdata;
   logic [bsp_pkg::DATA_W-1:0]  odd_rdata;
   logic                        even_we;
   logic [BANK_AW-1:0]          even_waddr;
   logic [bsp_pkg::DATA_W-1:0]  even_wdata;
   logic                        odd_we;
   logic [BANK_AW-1:0]          odd_waddr;
   logic [bsp_pkg::DATA_W-1:0]  odd_wdata;

   bsp_issue #(
      .STORE_WORDS (STORE_WORDS),
      .BANK_AW     (BANK_AW)
   ) u_issue (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .rd_addr_even (rd_addr_even),
      .rd_addr_odd  (rd_addr_odd),
      .s1_valid     (s1_valid),
      .s1_stage     (s1_stage)
   );

   bsp_ram #(
      .WIDTH  (bsp_pkg::DATA_W),
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (BANK_AW)
   ) u_even_bank (
      .clock (clock),
      .we    (even_we),
      .waddr (even_waddr),
      .wdata (even_wdata),
      .raddr (rd_addr_even),
      .rdata (even_rdata)
   );

   bsp_ram #(
      .WIDTH  (bsp_pkg::DATA_W),
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (BANK_AW)
   ) u_odd_bank (
      .clock (clock),
      .we    (odd_we),
      .waddr (odd_waddr),
      .wdata (odd_wdata),
      .raddr (rd_addr_odd),
      .rdata (odd_rdata)
   );

   bsp_merge #(
      .STORE_WORDS (STORE_WORDS),
      .BANK_AW     (BANK_AW)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_stage   (s1_stage),
      .even_rdata (even_rdata),
      .odd_rdata  (odd_rdata),
      .even_we    (even_we),
      .even_waddr (even_waddr),
      .even_wdata (even_wdata),
      .odd_we     (odd_we),
      .odd_waddr  (odd_waddr),
      .odd_wdata  (odd_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire
